>>> rtl/vve_pkg.sv
// ----------------------------------------------------------------------------
// vve_pkg
// Shared types and constants of the visible voxel extractor: register
// indexes, control word layout and the microprogram ROM.
// ----------------------------------------------------------------------------
package vve_pkg;

   localparam int COORD_W = 6;
   localparam int SIDE_W  = 7;
   localparam int COUNT_W = 13;
   localparam int SHADE_W = 2;
   localparam int ENTRY_W = 16;

   localparam logic REG_SIDE_IN_USE = 1'b0;
   localparam logic REG_TOP_ROW     = 1'b1;

   localparam logic CMD_WRITE    = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   localparam logic [SHADE_W-1:0] SHADE_NONE  = 2'd0;
   localparam logic [SHADE_W-1:0] SHADE_UP    = 2'd1;
   localparam logic [SHADE_W-1:0] SHADE_SIDE  = 2'd2;

   // memory address source
   typedef enum logic [2:0] {
      ADR_CENTRE,   // centre voxel straight from the request ports
      ADR_SELF,     // latched centre voxel
      ADR_UP,
      ADR_DOWN,
      ADR_LEFT,
      ADR_YP,
      ADR_YM,
      ADR_XP
   } addr_type;

   // which flag takes the data of the previous read
   typedef enum logic [2:0] {
      CAP_NONE,
      CAP_C,
      CAP_U,
      CAP_D,
      CAP_L,
      CAP_YP,
      CAP_YM
   } cap_type;

   typedef enum logic [2:0] {
      STEP_RD_U,
      STEP_RD_D,
      STEP_RD_L,
      STEP_RD_YP,
      STEP_RD_YM,
      STEP_RD_XP,
      STEP_EVAL,
      STEP_WRITE
   } step_type;

   typedef struct packed {
      addr_type adr_sel;
      cap_type  cap;
      logic     mem_we;
      logic     eval;
      logic     jump_skip;
      step_type jump_target;
      logic     last;
   } ctrl_word_type;

   localparam ctrl_word_type CW_IDLE = '{
      adr_sel:     ADR_CENTRE,
      cap:         CAP_NONE,
      mem_we:      1'b0,
      eval:        1'b0,
      jump_skip:   1'b0,
      jump_target: STEP_EVAL,
      last:        1'b0
   };

   function automatic ctrl_word_type rom_word(step_type s);
      ctrl_word_type w;
      w = CW_IDLE;
      case (s)
         STEP_RD_U: begin
            w.adr_sel   = ADR_UP;
            w.cap       = CAP_C;
            w.jump_skip = 1'b1;
         end
         STEP_RD_D: begin
            w.adr_sel = ADR_DOWN;
            w.cap     = CAP_U;
         end
         STEP_RD_L: begin
            w.adr_sel = ADR_LEFT;
            w.cap     = CAP_D;
         end
         STEP_RD_YP: begin
            w.adr_sel = ADR_YP;
            w.cap     = CAP_L;
         end
         STEP_RD_YM: begin
            w.adr_sel = ADR_YM;
            w.cap     = CAP_YP;
         end
         STEP_RD_XP: begin
            w.adr_sel = ADR_XP;
            w.cap     = CAP_YM;
         end
         STEP_EVAL: begin
            w.eval = 1'b1;
            w.last = 1'b1;
         end
         STEP_WRITE: begin
            w.adr_sel = ADR_SELF;
            w.mem_we  = 1'b1;
            w.last    = 1'b1;
         end
         default: w = CW_IDLE;
      endcase
      return w;
   endfunction

endpackage

>>> rtl/vve_store.sv
// ----------------------------------------------------------------------------
// vve_store
// Single-port occupancy memory, one bit per voxel, registered read data.
// ----------------------------------------------------------------------------
module vve_store #(
   parameter int AW = 18
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic          wdata,
   output logic          rdata
);

   logic mem [2**AW];
   logic rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/vve_seq.sv
// ----------------------------------------------------------------------------
// vve_seq
// Microprogram sequencer: step counter, ROM lookup, entry dispatch on the
// command and a conditional jump to the evaluation step.
// ----------------------------------------------------------------------------
module vve_seq
   import vve_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          launch,
   input  logic          is_write,
   input  logic          skip,
   output ctrl_word_type cw,
   output logic          running
);

   logic     running_ff;
   step_type step_ff;
   ctrl_word_type rom_cw;

   assign rom_cw  = rom_word(step_ff);
   assign cw      = running_ff ? rom_cw : CW_IDLE;
   assign running = running_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         step_ff    <= STEP_RD_U;
      end else if (!running_ff) begin
         if (launch) begin
            running_ff <= 1'b1;
            step_ff    <= is_write ? STEP_WRITE : STEP_RD_U;
         end
      end else if (rom_cw.last) begin
         running_ff <= 1'b0;
      end else if (rom_cw.jump_skip && skip) begin
         step_ff <= rom_cw.jump_target;
      end else begin
         step_ff <= step_type'(step_ff + 3'd1);
      end
   end

endmodule

>>> rtl/visible_voxel_extractor.sv
// ----------------------------------------------------------------------------
// visible_voxel_extractor
// Occupancy store with a six-neighbour visibility test and packed list
// entries for visible voxels.
//
// Use: drive start with a request on the req_ ports; it is taken at a rising
// edge with start high and busy low. A write (req_command 0) stores one
// occupancy bit. A classify (req_command 1) reads the centre voxel and up
// to six neighbours through the single memory port, one read a cycle; the
// neighbour reads are skipped when the centre is empty or lies outside the
// interior. A visible voxel gives one result: rsp_valid is high for one
// cycle, the last of the item, and the result is taken at the end of that
// cycle, with rsp_visible_entry and rsp_list_slot. The receiver cannot
// stall; results are never held back.
// Configuration writes on the csr_ port take effect at once and belong only
// in idle periods. Reset sets side_in_use to 64, top_row to 63, clears the
// shade and list count; the occupancy memory is not cleared and no voxel may
// be classified before it has been written.
// ----------------------------------------------------------------------------
module visible_voxel_extractor
   import vve_pkg::*;
#(
   parameter int SIDE = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_command,
   input  logic [COORD_W-1:0]  req_coord_x,
   input  logic [COORD_W-1:0]  req_coord_y,
   input  logic [COORD_W-1:0]  req_coord_z,
   input  logic [7:0]          req_voxel_value,
   input  logic                req_layer_start,
   input  logic                req_pass_start,
   output logic                rsp_valid,
   output logic [ENTRY_W-1:0]  rsp_visible_entry,
   output logic [COUNT_W-1:0]  rsp_list_slot,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [SIDE_W-1:0]   csr_wdata
);

   localparam int CW = $clog2(SIDE);
   localparam int AW = 3 * CW;
   localparam logic [7:0] SIDE_LIM = 8'(SIDE);

   ctrl_word_type cw;
   logic          running;
   logic          accept;

   logic [SIDE_W-1:0]  side_ff;
   logic [COORD_W-1:0] top_ff;

   logic               cmd_ff;
   logic [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic               val_nz_ff;
   logic               c_ff, u_ff, d_ff, l_ff, yp_ff, ym_ff;
   logic [SHADE_W-1:0] shade_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               ok_ff;

   logic               rsp_valid_ff;
   logic [ENTRY_W-1:0] rsp_entry_ff;
   logic [COUNT_W-1:0] rsp_slot_ff;

   logic [7:0]    ax, ay, az;
   logic          rd_ok;
   logic [AW-1:0] addr;
   logic          mem_rdata;
   logic          bit_rd;
   logic          interior;
   logic          nu, nd, nl;
   logic          enclosed, visible;
   logic [SHADE_W-1:0] shade_in;
   logic [COUNT_W-1:0] count_inc;

   assign accept = start && !busy;
   assign busy   = running;

   vve_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .launch   (accept),
      .is_write (req_command == CMD_WRITE),
      .skip     (!bit_rd || !interior),
      .cw       (cw),
      .running  (running)
   );

   // address of the voxel read or written this cycle
   always_comb begin
      ax = {2'b00, x_ff};
      ay = {2'b00, y_ff};
      az = {2'b00, z_ff};
      case (cw.adr_sel)
         ADR_CENTRE: begin
            ax = {2'b00, req_coord_x};
            ay = {2'b00, req_coord_y};
            az = {2'b00, req_coord_z};
         end
         ADR_SELF: ;
         ADR_UP:   az = az + 8'd1;
         ADR_DOWN: az = az - 8'd1;
         ADR_LEFT: ax = ax - 8'd1;
         ADR_YP:   ay = ay + 8'd1;
         ADR_YM:   ay = ay - 8'd1;
         ADR_XP:   ax = ax + 8'd1;
         default: ;
      endcase
   end

   // positions outside the store read as empty and take no write
   assign rd_ok = (ax < SIDE_LIM) && (ay < SIDE_LIM) && (az < SIDE_LIM);
   assign addr  = {CW'(ay), CW'(az), CW'(ax)};

   vve_store #(.AW(AW)) u_store (
      .clock (clock),
      .we    (cw.mem_we && rd_ok),
      .addr  (addr),
      .wdata (val_nz_ff),
      .rdata (mem_rdata)
   );

   assign bit_rd = mem_rdata && ok_ff;

   assign interior = (x_ff != '0) && (({1'b0, x_ff} + 7'd1) < side_ff)
                  && (y_ff != '0) && (({1'b0, y_ff} + 7'd1) < side_ff)
                  && (z_ff != '0) && (({1'b0, z_ff} + 7'd1) < side_ff);

   // neighbour flags only count inside the interior; last read is +x, live
   assign nu = interior && u_ff;
   assign nd = interior && d_ff;
   assign nl = interior && l_ff;
   assign enclosed = nu && nd && nl && interior && yp_ff && ym_ff && bit_rd;
   assign visible  = c_ff && !enclosed;

   always_comb begin
      shade_in = shade_ff;
      if ((nl && nd && nu) || (y_ff == top_ff)) begin
         shade_in = SHADE_NONE;
      end else begin
         if (!nl && nu) begin
            shade_in = SHADE_UP;
         end
         if (!nd && !nu && (x_ff != '0)) begin
            shade_in = SHADE_SIDE;
         end
         if (nl && !nd) begin
            shade_in = SHADE_SIDE;
         end
      end
   end

   assign count_inc = count_ff + 13'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= 7'd64;
         top_ff       <= 6'd63;
         shade_ff     <= SHADE_NONE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               REG_SIDE_IN_USE: side_ff <= csr_wdata;
               REG_TOP_ROW:     top_ff  <= csr_wdata[COORD_W-1:0];
               default: ;
            endcase
         end
         if (accept && (req_command == CMD_CLASSIFY)) begin
            if (req_layer_start) begin
               count_ff <= '0;
            end
            if (req_pass_start) begin
               shade_ff <= SHADE_NONE;
            end
         end
         if (cw.eval && visible) begin
            shade_ff     <= shade_in;
            count_ff     <= count_inc;
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      ok_ff <= rd_ok;
      if (accept) begin
         cmd_ff    <= req_command;
         x_ff      <= req_coord_x;
         y_ff      <= req_coord_y;
         z_ff      <= req_coord_z;
         val_nz_ff <= (req_voxel_value != 8'd0);
      end
      case (cw.cap)
         CAP_C:  c_ff  <= bit_rd;
         CAP_U:  u_ff  <= bit_rd;
         CAP_D:  d_ff  <= bit_rd;
         CAP_L:  l_ff  <= bit_rd;
         CAP_YP: yp_ff <= bit_rd;
         CAP_YM: ym_ff <= bit_rd;
         default: ;
      endcase
      if (cw.eval) begin
         rsp_entry_ff <= {shade_in, 1'b0, y_ff, 1'b0, x_ff};
         rsp_slot_ff  <= count_inc;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_visible_entry = rsp_entry_ff;
   assign rsp_list_slot     = rsp_slot_ff;

   // a result only follows an evaluation step of a classify
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && $past(cmd_ff == CMD_CLASSIFY)))
      else $error("result without a classify in progress");

   // the sequencer only starts on a transfer
   a_busy_on_transfer: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("sequencer started without a transfer");

   // at most one result per item
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");

   // the slot shown is the list count just reached
   a_slot_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_list_slot == count_ff))
      else $error("list slot and count disagree");

endmodule
